### src/ipv4_longest_prefix_match_macros.svh
// Assertion macros used by the checker file.
`ifndef IPV4_LONGEST_PREFIX_MATCH_MACROS_SVH
`define IPV4_LONGEST_PREFIX_MATCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/lpm_pkg.sv
`default_nettype none
package lpm_pkg;

	localparam int ADDR_W = 32;
	localparam int LEN_W  = 6;
	localparam int COST_W = 16;

	localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;
	localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} lpm_state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] hop;
		logic [COST_W-1:0] cost;
		logic [LEN_W-1:0]  length;
		logic [ADDR_W-1:0] prefix;
	} route_entry_t;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0]  prefix_len;
		logic [COST_W-1:0] metric;
		logic [ADDR_W-1:0] hop_in;
	} lpm_req_t;

	typedef struct packed {
		logic              matched;
		logic [ADDR_W-1:0] hop_out;
		logic              insert_dropped;
	} lpm_rsp_t;

	// Lengths of 32 and above give an all-ones mask; zero gives no bits.
	function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		return ~(ALL_ONES >> len);
	endfunction

endpackage
`default_nettype wire

### src/ipv4_longest_prefix_match.sv
// One item is worked on at a time: the next is taken only once the last one's result
// has gone into the output register, after a scan that reads every
// table entry once through the single read port of the route memory.
// A finished result waits in an output register while the next item is taken.
// Reset clears all entry valid bits at once; there is no clearing pass.
`default_nettype none
module ipv4_longest_prefix_match #(
	parameter int ROUTES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [31:0] address, [37:32] prefix_len, [53:38] metric, [85:54] hop_in
	input  wire logic [87:0] s_axis_tdata,
	// [0] mode
	input  wire logic        s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [0] matched, [32:1] hop_out, [33] insert_dropped
	output logic [39:0]      m_axis_tdata
);

	localparam int IW = (ROUTES > 1) ? $clog2(ROUTES) : 1;

	lpm_pkg::lpm_req_t     req;
	lpm_pkg::lpm_rsp_t     rsp;
	logic                  rd_en;
	logic [IW-1:0]         rd_addr;
	lpm_pkg::route_entry_t rd_entry_s1;
	logic                  rd_valid_s1;
	logic                  wr_en;
	logic [IW-1:0]         wr_addr;
	lpm_pkg::route_entry_t wr_entry;

	assign req.mode       = s_axis_tuser;
	assign req.address    = s_axis_tdata[31:0];
	assign req.prefix_len = s_axis_tdata[37:32];
	assign req.metric     = s_axis_tdata[53:38];
	assign req.hop_in     = s_axis_tdata[85:54];

	assign m_axis_tdata = {6'd0, rsp.insert_dropped, rsp.hop_out, rsp.matched};

	lpm_scan #(
		.ROUTES(ROUTES),
		.IW    (IW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_req     (req),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_rsp    (rsp),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_entry_s1(rd_entry_s1),
		.rd_valid_s1(rd_valid_s1),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_entry   (wr_entry)
	);

	lpm_table #(
		.ROUTES(ROUTES),
		.IW    (IW)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_entry_s1(rd_entry_s1),
		.rd_valid_s1(rd_valid_s1),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_entry   (wr_entry)
	);

endmodule
`default_nettype wire

### src/lpm_table.sv
`default_nettype none
module lpm_table #(
	parameter int ROUTES = 64,
	parameter int IW     = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  rd_en,
	input  wire logic [IW-1:0]         rd_addr,
	output lpm_pkg::route_entry_t      rd_entry_s1,
	output logic                       rd_valid_s1,
	input  wire logic                  wr_en,
	input  wire logic [IW-1:0]         wr_addr,
	input  wire lpm_pkg::route_entry_t wr_entry
);

	lpm_pkg::route_entry_t mem [ROUTES];
	logic [ROUTES-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_s1 <= mem[rd_addr];
		end
	end

	// Valid bits live in flops so that reset empties the table at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
		end
	end

endmodule
`default_nettype wire

### src/lpm_scan.sv
`default_nettype none
module lpm_scan #(
	parameter int ROUTES = 64,
	parameter int IW     = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire lpm_pkg::lpm_req_t     in_req,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output lpm_pkg::lpm_rsp_t          out_rsp,
	output logic                       rd_en,
	output logic [IW-1:0]              rd_addr,
	input  wire lpm_pkg::route_entry_t rd_entry_s1,
	input  wire logic                  rd_valid_s1,
	output logic                       wr_en,
	output logic [IW-1:0]              wr_addr,
	output lpm_pkg::route_entry_t      wr_entry
);

	localparam logic [IW-1:0] LAST_IDX = IW'(ROUTES - 1);

	lpm_pkg::lpm_state_t state_q, state_d;

	logic [IW-1:0] idx_q;
	logic          proc_s1;
	logic [IW-1:0] proc_idx_s1;

	// Item being worked on; for an insert the address is already masked.
	logic                         mode_q;
	logic [lpm_pkg::ADDR_W-1:0]   addr_q;
	logic [lpm_pkg::LEN_W-1:0]    len_q;
	logic [lpm_pkg::COST_W-1:0]   cost_q;
	logic [lpm_pkg::ADDR_W-1:0]   hop_q;

	logic                         found_q;
	logic [lpm_pkg::LEN_W-1:0]    best_len_q;
	logic [lpm_pkg::ADDR_W-1:0]   best_hop_q;
	logic                         hit_q;
	logic [IW-1:0]                hit_idx_q;
	logic [lpm_pkg::COST_W-1:0]   hit_cost_q;
	logic                         free_q;
	logic [IW-1:0]                free_idx_q;

	logic                         out_valid_q;
	lpm_pkg::lpm_rsp_t            out_rsp_q;

	logic                         accept;
	logic                         finish;
	logic [lpm_pkg::LEN_W-1:0]    in_len_sat;
	logic                         covers;
	logic                         same_key;

	assign in_len_sat = (in_req.prefix_len > lpm_pkg::MAX_LEN) ? lpm_pkg::MAX_LEN
		: in_req.prefix_len;
	assign covers = rd_valid_s1 &&
		((addr_q & lpm_pkg::len_mask(rd_entry_s1.length)) == rd_entry_s1.prefix);
	assign same_key = rd_valid_s1 && (rd_entry_s1.length == len_q) &&
		(rd_entry_s1.prefix == addr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		finish   = 1'b0;
		case (state_q)
			lpm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = lpm_pkg::ST_SCAN;
				end
			end
			lpm_pkg::ST_SCAN: begin
				rd_en = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = lpm_pkg::ST_DRAIN;
				end
			end
			lpm_pkg::ST_DRAIN: begin
				state_d = lpm_pkg::ST_DONE;
			end
			lpm_pkg::ST_DONE: begin
				// The result and the table update go out together once the
				// output register is free.
				if (!out_valid_q || out_ready) begin
					finish  = 1'b1;
					state_d = lpm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lpm_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept  = in_valid && in_ready;
	assign rd_addr = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			proc_s1 <= 1'b0;
		end else begin
			proc_s1 <= rd_en;
			if (accept) begin
				idx_q <= '0;
			end else if (rd_en && idx_q != LAST_IDX) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		proc_idx_s1 <= idx_q;
		if (accept) begin
			mode_q <= in_req.mode;
			len_q  <= in_len_sat;
			cost_q <= in_req.metric;
			hop_q  <= in_req.hop_in;
			if (in_req.mode == lpm_pkg::MODE_INSERT) begin
				addr_q <= in_req.address & lpm_pkg::len_mask(in_len_sat);
			end else begin
				addr_q <= in_req.address;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
		end else if (accept) begin
			found_q <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
		end else if (proc_s1) begin
			if (covers && (!found_q || rd_entry_s1.length > best_len_q)) begin
				found_q <= 1'b1;
			end
			if (same_key) begin
				hit_q <= 1'b1;
			end
			if (!rd_valid_s1) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc_s1) begin
			if (covers && (!found_q || rd_entry_s1.length > best_len_q)) begin
				best_len_q <= rd_entry_s1.length;
				best_hop_q <= rd_entry_s1.hop;
			end
			if (same_key) begin
				hit_idx_q  <= proc_idx_s1;
				hit_cost_q <= rd_entry_s1.cost;
			end
			if (!rd_valid_s1 && !free_q) begin
				free_idx_q <= proc_idx_s1;
			end
		end
	end

	always_comb begin
		wr_en           = 1'b0;
		wr_addr         = hit_q ? hit_idx_q : free_idx_q;
		wr_entry.prefix = addr_q;
		wr_entry.length = len_q;
		wr_entry.cost   = cost_q;
		wr_entry.hop    = hop_q;
		if (finish && mode_q == lpm_pkg::MODE_INSERT) begin
			wr_en = hit_q ? (cost_q < hit_cost_q) : free_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_rsp_q.matched        <= (mode_q == lpm_pkg::MODE_LOOKUP) && found_q;
			out_rsp_q.hop_out        <= ((mode_q == lpm_pkg::MODE_LOOKUP) && found_q)
				? best_hop_q : '0;
			out_rsp_q.insert_dropped <= (mode_q == lpm_pkg::MODE_INSERT) && !hit_q
				&& !free_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

endmodule
`default_nettype wire

### src/lpm_checker.sv
`default_nettype none
`include "ipv4_longest_prefix_match_macros.svh"
module lpm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [87:0] s_axis_tdata,
	input wire logic        s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata
);

	`LPM_ASSERT_NOW(a_match_xor_drop, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[33]), "result both matched and dropped")
	`LPM_ASSERT_NOW(a_nomatch_zero_hop, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[32:1] == 32'd0, "unmatched result carries a nonzero hop")
	`LPM_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready stayed high after an input transfer")
	`LPM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind ipv4_longest_prefix_match lpm_checker u_lpm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int TABLE_SIZE = 64;
	localparam int LIMIT = 400000;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int HOLD_OFF_AT = 200;

	typedef struct {
		lpm_pkg::lpm_req_t req;
		bit                wait_drain;
	} feed_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	ipv4_longest_prefix_match #(.ROUTES(TABLE_SIZE)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Shadow copy of the route table.
	bit                         route_ok [TABLE_SIZE];
	logic [lpm_pkg::ADDR_W-1:0] route_key [TABLE_SIZE];
	logic [lpm_pkg::LEN_W-1:0]  route_len [TABLE_SIZE];
	logic [lpm_pkg::COST_W-1:0] route_cost [TABLE_SIZE];
	logic [lpm_pkg::ADDR_W-1:0] route_hop [TABLE_SIZE];

	feed_item_t        request_fifo[$];
	lpm_pkg::lpm_rsp_t result_fifo[$];
	lpm_pkg::lpm_req_t cur_req;

	int errors = 0;
	int results = 0;
	int lookups = 0;
	int match_count = 0;
	int inserts = 0;
	int drops = 0;
	int cost_updates = 0;
	int cycle_count = 0;

	int gap_left = 0;
	int drv_calm = 0;
	int stall_left = 0;
	int mon_calm = 0;
	bit held_off = 0;

	function automatic logic [lpm_pkg::ADDR_W-1:0] prefix_mask(input int len);
		return (len == 0) ? '0 : lpm_pkg::ALL_ONES << (32 - len);
	endfunction

	// Applies one request to the shadow table and returns the result it must produce.
	function automatic lpm_pkg::lpm_rsp_t route_table_apply(input lpm_pkg::lpm_req_t rq);
		lpm_pkg::lpm_rsp_t          rsp;
		logic [lpm_pkg::LEN_W-1:0]  len;
		logic [lpm_pkg::ADDR_W-1:0] key;
		logic [lpm_pkg::LEN_W-1:0]  best_len;
		int                         slot;
		bit                         hit;
		rsp = '0;
		slot = -1;
		hit = 0;
		best_len = '0;
		if (rq.mode == lpm_pkg::MODE_INSERT) begin
			inserts++;
			len = (rq.prefix_len > lpm_pkg::MAX_LEN) ? lpm_pkg::MAX_LEN : rq.prefix_len;
			key = rq.address & prefix_mask(len);
			for (int i = 0; i < TABLE_SIZE; i++) begin
				if (route_ok[i]) begin
					if (!hit && route_len[i] == len && route_key[i] == key) begin
						hit = 1;
						if (rq.metric < route_cost[i]) begin
							route_cost[i] = rq.metric;
							route_hop[i] = rq.hop_in;
							cost_updates++;
						end
					end
				end else if (slot < 0) begin
					slot = i;
				end
			end
			if (!hit) begin
				if (slot < 0) begin
					rsp.insert_dropped = 1'b1;
					drops++;
				end else begin
					route_ok[slot] = 1;
					route_key[slot] = key;
					route_len[slot] = len;
					route_cost[slot] = rq.metric;
					route_hop[slot] = rq.hop_in;
				end
			end
		end else begin
			lookups++;
			for (int i = 0; i < TABLE_SIZE; i++) begin
				if (route_ok[i] && (rq.address & prefix_mask(route_len[i])) == route_key[i]
						&& (!hit || route_len[i] > best_len)) begin
					hit = 1;
					best_len = route_len[i];
					rsp.hop_out = route_hop[i];
				end
			end
			rsp.matched = hit;
			if (hit)
				match_count++;
		end
		return rsp;
	endfunction

	task automatic add_item(input logic mode, input logic [lpm_pkg::ADDR_W-1:0] addr,
			input logic [lpm_pkg::LEN_W-1:0] len, input logic [lpm_pkg::COST_W-1:0] cost,
			input logic [lpm_pkg::ADDR_W-1:0] hop, input bit drain);
		feed_item_t it;
		it.req.mode = mode;
		it.req.address = addr;
		it.req.prefix_len = len;
		it.req.metric = cost;
		it.req.hop_in = hop;
		it.wait_drain = drain;
		request_fifo.push_back(it);
	endtask

	// Sender: one transfer per queued request, with a random gap after each one outside calm stretches.
	always @(posedge clk or negedge arst_n) begin : feed
		feed_item_t nxt;
		int         gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready)
				result_fifo.push_back(route_table_apply(cur_req));
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (request_fifo.size() != 0
						&& !(request_fifo[0].wait_drain && result_fifo.size() != 0)) begin
					nxt = request_fifo.pop_front();
					if (drv_calm != 0) begin
						drv_calm--;
						gap = 0;
					end else begin
						if ($urandom_range(0, 49) == 0)
							drv_calm = 30;
						gap = $urandom_range(0, 7);
					end
					cur_req <= nxt.req;
					s_tdata <= {2'b00, nxt.req.hop_in, nxt.req.metric,
						nxt.req.prefix_len, nxt.req.address};
					s_tuser <= nxt.req.mode;
					s_tvalid <= 1'b1;
					gap_left <= gap;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result transfer and stalls at random afterwards.
	always @(posedge clk or negedge arst_n) begin : sink
		lpm_pkg::lpm_rsp_t got;
		lpm_pkg::lpm_rsp_t want;
		int                stall;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.matched = m_tdata[0];
				got.hop_out = m_tdata[32:1];
				got.insert_dropped = m_tdata[33];
				results++;
				if (result_fifo.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got %h", $time, got);
				end else begin
					want = result_fifo.pop_front();
					if (got.matched !== want.matched) begin
						errors++;
						$display("%0t: matched mismatch, expected %b, got %b",
							$time, want.matched, got.matched);
					end
					if (got.hop_out !== want.hop_out) begin
						errors++;
						$display("%0t: hop_out mismatch, expected %h, got %h",
							$time, want.hop_out, got.hop_out);
					end
					if (got.insert_dropped !== want.insert_dropped) begin
						errors++;
						$display("%0t: insert_dropped mismatch, expected %b, got %b",
							$time, want.insert_dropped, got.insert_dropped);
					end
				end
				// Once in the run the receiver holds off long enough for the block to back up.
				if (!held_off && results == HOLD_OFF_AT) begin
					held_off = 1;
					stall = HOLD_OFF_CYCLES;
				end else if (mon_calm != 0) begin
					mon_calm--;
					stall = 0;
				end else begin
					if ($urandom_range(0, 49) == 0)
						mon_calm = 30;
					stall = $urandom_range(0, 7);
				end
				stall_left <= stall;
				m_tready <= (stall == 0);
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready <= (stall_left == 1);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : stimulus
		logic [lpm_pkg::ADDR_W-1:0] base [4];
		logic [lpm_pkg::ADDR_W-1:0] addr_pool[$];
		int                         len_pool[$];
		logic [lpm_pkg::ADDR_W-1:0] a;
		logic [lpm_pkg::ADDR_W-1:0] m;
		int                         l;
		int                         k;
		int                         p;
		int                         r;

		for (int i = 0; i < 4; i++)
			base[i] = $urandom;

		// Empty table first, then default route, host routes and nested prefixes.
		add_item(lpm_pkg::MODE_LOOKUP, 32'h0000_0000, '0, '0, '0, 0);
		add_item(lpm_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, 0);
		add_item(lpm_pkg::MODE_INSERT, 32'hC0A8_0000, 6'd0, 16'd100, 32'h0A00_0001, 0);
		add_item(lpm_pkg::MODE_LOOKUP, 32'h0000_0000, '0, '0, '0, 0);
		add_item(lpm_pkg::MODE_INSERT, 32'hFFFF_FFFF, 6'd32, 16'hFFFF, 32'hFFFF_FFFF, 0);
		add_item(lpm_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, 0);
		add_item(lpm_pkg::MODE_LOOKUP, 32'hFFFF_FFFE, '0, '0, '0, 0);
		// Lengths above 32 alias the host route; equal cost leaves it alone.
		add_item(lpm_pkg::MODE_INSERT, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 32'h1234_5678, 0);
		add_item(lpm_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, 0);
		add_item(lpm_pkg::MODE_INSERT, 32'hFFFF_FFFF, 6'd33, 16'h0000, 32'h0000_0000, 0);
		add_item(lpm_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, 0);
		add_item(lpm_pkg::MODE_INSERT, 32'hC0A8_0137, 6'd24, 16'd50, 32'h0A00_0002, 0);
		add_item(lpm_pkg::MODE_INSERT, 32'hC0A8_0100, 6'd16, 16'd50, 32'h0A00_0003, 0);
		add_item(lpm_pkg::MODE_LOOKUP, 32'hC0A8_01FF, '0, '0, '0, 0);
		add_item(lpm_pkg::MODE_LOOKUP, 32'hC0A8_02FF, '0, '0, '0, 0);
		add_item(lpm_pkg::MODE_INSERT, 32'hC0A8_01AA, 6'd24, 16'd60, 32'h0A00_0009, 0);
		add_item(lpm_pkg::MODE_INSERT, 32'hC0A8_0100, 6'd24, 16'd49, 32'h0A00_0004, 0);
		add_item(lpm_pkg::MODE_LOOKUP, 32'hC0A8_0105, '0, '0, '0, 0);
		add_item(lpm_pkg::MODE_INSERT, 32'h8000_0000, 6'd1, 16'd7, 32'hDEAD_BEEF, 0);
		add_item(lpm_pkg::MODE_LOOKUP, 32'h8000_0001, '0, '0, '0, 0);
		add_item(lpm_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, '0, '0, '0, 0);
		add_item(lpm_pkg::MODE_INSERT, 32'h0000_0000, 6'd32, 16'd0, 32'h0101_0101, 0);
		add_item(lpm_pkg::MODE_LOOKUP, 32'h0000_0000, '0, '0, '0, 0);

		// Random part: most new prefixes grow from four base addresses so that they nest.
		for (int n = 0; n < 830; n++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				a = $urandom;
				if (r < 35 && addr_pool.size() != 0) begin
					p = $urandom_range(0, addr_pool.size() - 1);
					m = prefix_mask(len_pool[p]);
					a = (addr_pool[p] & m) | (a & ~m);
				end
				add_item(lpm_pkg::MODE_LOOKUP, a, 6'($urandom), 16'($urandom), $urandom,
					n == 0 || n == 450);
			end else if (r < 65 && addr_pool.size() != 0) begin
				p = $urandom_range(0, addr_pool.size() - 1);
				m = prefix_mask(len_pool[p]);
				a = (addr_pool[p] & m) | ($urandom & ~m);
				l = len_pool[p];
				if (l == 32 && $urandom_range(0, 1) == 1)
					l = $urandom_range(33, 63);
				add_item(lpm_pkg::MODE_INSERT, a, 6'(l), 16'($urandom), $urandom,
					n == 0 || n == 450);
			end else begin
				if (r < 92) begin
					k = $urandom_range(0, 32);
					m = prefix_mask(k);
					a = (base[$urandom_range(0, 3)] & m) | ($urandom & ~m);
				end else begin
					a = $urandom;
				end
				l = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 32);
				addr_pool.push_back(a);
				len_pool.push_back((l > 32) ? 32 : l);
				add_item(lpm_pkg::MODE_INSERT, a, 6'(l), 16'($urandom), $urandom,
					n == 0 || n == 450);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (request_fifo.size() != 0 || s_tvalid)
			@(posedge clk);
		while (result_fifo.size() != 0)
			@(posedge clk);
		repeat (TABLE_SIZE + 20) @(posedge clk);

		$display("Checked %0d results: %0d lookups (%0d matched), %0d inserts", results,
			lookups, match_count, inserts);
		$display("Inserts dropped on a full table: %0d, routes replaced by lower cost: %0d",
			drops, cost_updates);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### ipv4_longest_prefix_match.f
+incdir+src
src/lpm_pkg.sv
src/lpm_table.sv
src/lpm_scan.sv
src/ipv4_longest_prefix_match.sv
src/lpm_checker.sv
dv/tb.sv
